@@ rtl/core/dense_layer_sgd_engine_assert.svh @@
// ---------------------------------------------------------------------------
// dense_layer_sgd_engine assertion macros
// shared concurrent assertion forms for the engine modules
// ---------------------------------------------------------------------------
`ifndef DENSE_LAYER_SGD_ENGINE_ASSERT_SVH
`define DENSE_LAYER_SGD_ENGINE_ASSERT_SVH

// condition implies consequence in the same cycle
`define DLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define DLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/dls_pkg.sv @@
// ---------------------------------------------------------------------------
// dls_pkg
// shared types and codes of the dense layer engine
// ---------------------------------------------------------------------------
package dls_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;

  localparam logic [2:0] CMD_WR_WEIGHT = 3'd0;
  localparam logic [2:0] CMD_WR_BIAS   = 3'd1;
  localparam logic [2:0] CMD_FORWARD   = 3'd2;
  localparam logic [2:0] CMD_BACKWARD  = 3'd3;
  localparam logic [2:0] CMD_RD_WEIGHT = 3'd4;
  localparam logic [2:0] CMD_RD_BIAS   = 3'd5;

  localparam logic [1:0] KIND_OUTPUT   = 2'd0;
  localparam logic [1:0] KIND_IN_GRAD  = 2'd1;
  localparam logic [1:0] KIND_WEIGHT   = 2'd2;
  localparam logic [1:0] KIND_BIAS     = 2'd3;

  localparam logic [1:0] CFG_INPUT_COUNT   = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT  = 2'd1;
  localparam logic [1:0] CFG_LEARNING_RATE = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         index;
    logic signed [15:0] value_res;
    logic               saturated;
    logic               last_res;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    logic       wr_item;
    logic       save_input;
    logic       gl_load;
    logic       w_rd;
    logic       mul_load;
    logic       f_acc;
    logic       b_acc;
    logic       bias_step;
    logic       out_load;
    logic       clr_sums;
    logic [3:0] k;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] row;
    logic [3:0] col;
    logic       last;
    logic [4:0] ni;
    logic [4:0] no;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/core/dls_datapath.sv @@
// ---------------------------------------------------------------------------
// dls_datapath
// stores, multipliers, accumulators and result register of the engine
// ---------------------------------------------------------------------------
module dls_datapath import dls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  output dp_status_t sts,
  input  in_item_t   in_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam logic [4:0] NI_MAX = 5'(MAX_INPUTS);
  localparam logic [4:0] NO_MAX = 5'(MAX_OUTPUTS);

  function automatic logic signed [39:0] sat40_f(input logic signed [40:0] v);
    if (v[40] != v[39]) return v[40] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
    return v[39:0];
  endfunction

  // returns {clip, value}
  function automatic logic [16:0] sat16_f(input logic signed [32:0] v);
    if (v > 33'sd32767) return {1'b1, 16'h7fff};
    if (v < -33'sd32768) return {1'b1, 16'h8000};
    return {1'b0, v[15:0]};
  endfunction

  in_item_t item;
  logic [4:0]  input_count, output_count;
  logic [15:0] learning_rate;
  logic [4:0]  ni, no;

  logic signed [15:0] weight_mem [0:255];
  logic signed [15:0] bias_mem [0:15];
  logic signed [15:0] saved_mem [0:15];
  logic signed [39:0] out_sums [0:15];
  logic signed [39:0] grad_sums [0:15];

  logic signed [15:0] wdata, wold, x_reg;
  logic signed [32:0] gl;
  logic signed [31:0] prod_a;
  logic signed [48:0] prod_b;

  logic [7:0]         waddr;
  logic               wwe;
  logic signed [15:0] wwdata;
  logic [3:0]         bidx;
  logic signed [15:0] bias_rd;
  logic               fwd;

  logic signed [49:0] wst;
  logic signed [25:0] wstep;
  logic signed [26:0] wdiff;
  logic [16:0]        w_sat;
  logic signed [33:0] bst;
  logic signed [17:0] bstep;
  logic signed [18:0] bdiff;
  logic [16:0]        b_sat;
  logic signed [39:0] o_new, g_new;
  logic signed [39:0] e_sum, e_pre;
  logic signed [40:0] e_biased, e_round;
  logic [16:0]        e_sat;
  logic [4:0]         e_n;

  assign fwd = (item.command == CMD_FORWARD);

  // effective counts clamp to 1..max
  always_comb begin
    if (input_count == 5'd0) ni = 5'd1;
    else if (input_count > NI_MAX) ni = NI_MAX;
    else ni = input_count;
    if (output_count == 5'd0) no = 5'd1;
    else if (output_count > NO_MAX) no = NO_MAX;
    else no = output_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_count   <= 5'd16;
      output_count  <= 5'd16;
      learning_rate <= 16'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT:   input_count   <= cfg_data[4:0];
        CFG_OUTPUT_COUNT:  output_count  <= cfg_data[4:0];
        CFG_LEARNING_RATE: learning_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_data;
  end

  // weight memory, row-major, one port per direction
  always_comb begin
    unique case (item.command)
      CMD_FORWARD:  waddr = {cmd.k, item.col};
      CMD_BACKWARD: waddr = {item.row, cmd.k};
      default:      waddr = {item.row, item.col};
    endcase
  end

  assign wwe    = (cmd.wr_item && item.command == CMD_WR_WEIGHT) || cmd.b_acc;
  assign wwdata = cmd.b_acc ? signed'(w_sat[15:0]) : item.value;

  always_ff @(posedge clk) begin
    if (wwe) weight_mem[waddr] <= wwdata;
    if (cmd.w_rd) begin
      wdata <= weight_mem[waddr];
      x_reg <= saved_mem[cmd.k];
    end
  end

  assign bidx    = fwd ? cmd.k : item.row;
  assign bias_rd = bias_mem[bidx];

  always_ff @(posedge clk) begin
    if (cmd.wr_item && item.command == CMD_WR_BIAS) bias_mem[item.row] <= item.value;
    else if (cmd.bias_step) bias_mem[item.row] <= b_sat[15:0];
    if (cmd.save_input) saved_mem[item.col] <= item.value;
  end

  always_ff @(posedge clk) begin
    if (cmd.gl_load) gl <= item.value * $signed({1'b0, learning_rate});
    if (cmd.mul_load) begin
      prod_a <= wdata * item.value;
      prod_b <= gl * x_reg;
      wold   <= wdata;
    end
  end

  // weight step and bias step, round half up
  always_comb begin
    wst   = {prod_b[48], prod_b} + 50'sd8388608;
    wstep = wst[49:24];
    wdiff = {{11{wold[15]}}, wold} - {wstep[25], wstep};
    w_sat = sat16_f({{6{wdiff[26]}}, wdiff});
    bst   = {gl[32], gl} + 34'sd32768;
    bstep = bst[33:16];
    bdiff = {{3{bias_rd[15]}}, bias_rd} - {bstep[17], bstep};
    b_sat = sat16_f({{14{bdiff[18]}}, bdiff});
    o_new = sat40_f({out_sums[cmd.k][39], out_sums[cmd.k]} + {{9{prod_a[31]}}, prod_a});
    g_new = sat40_f({grad_sums[cmd.k][39], grad_sums[cmd.k]} + {{9{prod_a[31]}}, prod_a});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        out_sums[i]  <= '0;
        grad_sums[i] <= '0;
      end
    end else begin
      if (cmd.f_acc) out_sums[cmd.k] <= o_new;
      if (cmd.b_acc) grad_sums[cmd.k] <= g_new;
      if (cmd.clr_sums) begin
        for (int i = 0; i < 16; i++) begin
          if (fwd) out_sums[i] <= '0;
          else grad_sums[i] <= '0;
        end
      end
    end
  end

  // emit value of element k
  always_comb begin
    e_sum    = fwd ? out_sums[cmd.k] : grad_sums[cmd.k];
    e_biased = {e_sum[39], e_sum} + {{17{bias_rd[15]}}, bias_rd, 8'd0};
    e_pre    = fwd ? sat40_f(e_biased) : e_sum;
    e_round  = {e_pre[39], e_pre} + 41'sd128;
    e_sat    = sat16_f(e_round[40:8]);
    e_n      = fwd ? no : ni;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (item.command)
        CMD_RD_WEIGHT: out_data <= '{KIND_WEIGHT, item.col, wdata, 1'b0, 1'b1};
        CMD_RD_BIAS:   out_data <= '{KIND_BIAS, item.row, bias_rd, 1'b0, 1'b1};
        CMD_FORWARD:   out_data <= '{KIND_OUTPUT, cmd.k, e_sat[15:0], e_sat[16],
                                     {1'b0, cmd.k} == e_n - 5'd1};
        default:       out_data <= '{KIND_IN_GRAD, cmd.k, e_sat[15:0], e_sat[16],
                                     {1'b0, cmd.k} == e_n - 5'd1};
      endcase
    end
  end

  always_comb begin
    sts.command  = item.command;
    sts.row      = item.row;
    sts.col      = item.col;
    sts.last     = item.last;
    sts.ni       = ni;
    sts.no       = no;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

@@ rtl/core/dls_controller.sv @@
// ---------------------------------------------------------------------------
// dls_controller
// sequencer that walks one item through the datapath
// ---------------------------------------------------------------------------
`include "dense_layer_sgd_engine_assert.svh"

module dls_controller import dls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_F_RD   = 4'd2;
  localparam logic [3:0] S_F_MUL  = 4'd3;
  localparam logic [3:0] S_F_ACC  = 4'd4;
  localparam logic [3:0] S_B_RD   = 4'd5;
  localparam logic [3:0] S_B_MUL  = 4'd6;
  localparam logic [3:0] S_B_ACC  = 4'd7;
  localparam logic [3:0] S_B_BIAS = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_RD_OUT = 4'd10;

  logic [3:0] state, state_next;
  logic [3:0] k, k_next;
  logic [4:0] emit_n;

  assign emit_n = (sts.command == CMD_FORWARD) ? sts.no : sts.ni;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.k      = k;
    in_ready   = 1'b0;
    state_next = state;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        k_next = '0;
        unique case (sts.command) inside
          CMD_WR_WEIGHT, CMD_WR_BIAS: begin
            cmd.wr_item = 1'b1;
            state_next  = S_IDLE;
          end
          CMD_FORWARD: begin
            if ({1'b0, sts.col} < sts.ni) begin
              cmd.save_input = 1'b1;
              state_next     = S_F_RD;
            end else begin
              state_next = sts.last ? S_EMIT : S_IDLE;
            end
          end
          CMD_BACKWARD: begin
            if ({1'b0, sts.row} < sts.no) begin
              cmd.gl_load = 1'b1;
              state_next  = S_B_RD;
            end else begin
              state_next = sts.last ? S_EMIT : S_IDLE;
            end
          end
          CMD_RD_WEIGHT: begin
            cmd.w_rd   = 1'b1;
            state_next = S_RD_OUT;
          end
          CMD_RD_BIAS: state_next = S_RD_OUT;
          default:     state_next = S_IDLE;
        endcase
      end
      S_F_RD: begin
        cmd.w_rd   = 1'b1;
        state_next = S_F_MUL;
      end
      S_F_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_F_ACC;
      end
      S_F_ACC: begin
        cmd.f_acc = 1'b1;
        if ({1'b0, k} == sts.no - 5'd1) begin
          k_next     = '0;
          state_next = sts.last ? S_EMIT : S_IDLE;
        end else begin
          k_next     = k + 4'd1;
          state_next = S_F_RD;
        end
      end
      S_B_RD: begin
        cmd.w_rd   = 1'b1;
        state_next = S_B_MUL;
      end
      S_B_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_B_ACC;
      end
      S_B_ACC: begin
        cmd.b_acc = 1'b1;
        if ({1'b0, k} == sts.ni - 5'd1) begin
          k_next     = '0;
          state_next = S_B_BIAS;
        end else begin
          k_next     = k + 4'd1;
          state_next = S_B_RD;
        end
      end
      S_B_BIAS: begin
        cmd.bias_step = 1'b1;
        state_next    = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if ({1'b0, k} == emit_n - 5'd1) begin
            cmd.clr_sums = 1'b1;
            k_next       = '0;
            state_next   = S_IDLE;
          end else begin
            k_next = k + 4'd1;
          end
        end
      end
      S_RD_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `DLS_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, sts.out_free, "result loaded over pending transfer")
  `DLS_ASSERT_NXT(a_accept_decode, clk, rst, in_valid && in_ready, state == S_DECODE, "accepted item not decoded")
  `DLS_ASSERT_IMP(a_fwd_range, clk, rst, cmd.f_acc, {1'b0, k} < sts.no, "forward index past output count")
  `DLS_ASSERT_IMP(a_bwd_range, clk, rst, cmd.b_acc, {1'b0, k} < sts.ni, "gradient index past input count")

endmodule

@@ rtl/core/dense_layer_sgd_engine.sv @@
// ---------------------------------------------------------------------------
// dense_layer_sgd_engine
// single-sample fully connected layer with forward pass, backward pass and
// sgd weight update, q8.8 values with saturation
// ---------------------------------------------------------------------------
//
//   channel | signals                             | transfer when
//   --------+-------------------------------------+--------------------------
//   in      | in_valid, in_ready, in_data         | in_valid && in_ready
//   out     | out_valid, out_ready, out_data      | out_valid && out_ready
//   cfg     | cfg_we, cfg_index, cfg_data         | cfg_we
//
// one item at a time; a weight or bias write is done in decode, a read goes on
// to an output state; forward element: a read, multiply, accumulate walk over
// the output count on the single-port weight memory
// backward element: a read, multiply, accumulate walk over the input count,
// then the bias update
// an emit loads one result at a time, each once the output register is free
// synchronous reset clears control and accumulators and sets the counts to
// 16; stores are undefined until written, and a stalled output holds the
// sequencer
module dense_layer_sgd_engine import dls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // sequencer: decodes the held item and steps the element index
  dls_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: stores, products, accumulators, result register
  dls_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
